FILE: hdl/iat_pkg.sv
// Shared types, constants and character helpers for the indentation-aware tokenizer.
// Used by iat_div, iat_ctrl, iat_dp and indent_aware_tokenizer; depends on nothing.
package iat_pkg;

   localparam int MAX_INDENT_DEPTH = 16;
   localparam int POSITION_BITS    = 24;
   localparam int TOP_W            = $clog2(MAX_INDENT_DEPTH);
   localparam int DEDENT_CAP       = 17;
   localparam int POPS_W           = $clog2(DEDENT_CAP + 1);
   localparam int SPACE_W          = 16;
   localparam int DIV_STEPS        = SPACE_W;
   localparam int DIV_CNT_W        = $clog2(DIV_STEPS + 1);

   // token kinds
   localparam logic [5:0] KIND_INT    = 6'd28;
   localparam logic [5:0] KIND_FLOAT  = 6'd29;
   localparam logic [5:0] KIND_STRING = 6'd30;
   localparam logic [5:0] KIND_CHAR   = 6'd31;
   localparam logic [5:0] KIND_KW0    = 6'd32;
   localparam logic [5:0] KIND_IDENT  = 6'd43;
   localparam logic [5:0] KIND_EOL    = 6'd44;
   localparam logic [5:0] KIND_EOF    = 6'd45;
   localparam logic [5:0] KIND_INDENT = 6'd46;
   localparam logic [5:0] KIND_DEDENT = 6'd47;
   localparam logic [5:0] KIND_ERROR  = 6'd48;
   localparam logic [5:0] KIND_NONE   = 6'd63;

   // error codes
   localparam logic [2:0] ERR_NONE       = 3'd0;
   localparam logic [2:0] ERR_INDENT     = 3'd1;
   localparam logic [2:0] ERR_CHAR_LIT   = 3'd2;
   localparam logic [2:0] ERR_OPEN_STR   = 3'd3;
   localparam logic [2:0] ERR_BAD_BYTE   = 3'd4;
   localparam logic [2:0] ERR_INDENT_OVF = 3'd5;

   // register index
   localparam logic REG_INDENT_WIDTH = 1'b0;

   // characters
   localparam logic [7:0] CH_NUL   = 8'h00;
   localparam logic [7:0] CH_NL    = 8'h0A;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_DQ    = 8'h22;
   localparam logic [7:0] CH_SQ    = 8'h27;
   localparam logic [7:0] CH_DOT   = 8'h2E;
   localparam logic [7:0] CH_BS    = 8'h5C;
   localparam logic [7:0] CH_USCORE = 8'h5F;

   localparam logic [63:0] KW_STR [11] = '{
      64'("break"), 64'("continue"), 64'("else"), 64'("false"), 64'("function"),
      64'("if"), 64'("let"), 64'("nil"), 64'("return"), 64'("true"), 64'("while")};
   localparam logic [3:0] KW_LEN [11] = '{
      4'd5, 4'd8, 4'd4, 4'd5, 4'd8, 4'd2, 4'd3, 4'd3, 4'd6, 4'd4, 4'd5};

   typedef enum logic [3:0] {
      CMD_NONE,
      CMD_LOAD,
      CMD_PRE,
      CMD_LS_SPACE,
      CMD_DIV_START,
      CMD_SETTLE,
      CMD_POP,
      CMD_SETTLE_END,
      CMD_CHAR,
      CMD_FLUSH
   } cmd_type;

   typedef struct packed {
      logic can_push;
      logic pre_emit;
      logic pre_scan;
      logic line_start;
      logic char_space;
      logic char_emit;
      logic settle_emit;
      logic settle_pop;
      logic pop_more;
      logic pop_emit;
      logic div_busy;
   } status_type;

   typedef struct packed {
      logic [5:0]  kind;
      logic [2:0]  err;
      logic [23:0] start;
      logic [15:0] len;
      logic [23:0] line;
      logic [15:0] col;
   } tok_type;

   function automatic logic is_digit(input logic [7:0] c);
      return (c >= 8'h30) && (c <= 8'h39);
   endfunction

   function automatic logic is_alpha(input logic [7:0] c);
      return ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A));
   endfunction

   function automatic logic is_word(input logic [7:0] c);
      return is_alpha(c) || is_digit(c) || (c == CH_USCORE);
   endfunction

   function automatic logic is_op2_start(input logic [7:0] c);
      return (c == 8'h2A) || (c == 8'h3E) || (c == 8'h3C) || (c == 8'h26) ||
             (c == 8'h7C) || (c == 8'h21) || (c == 8'h3D);
   endfunction

   // one-byte operators that never look ahead
   function automatic logic [5:0] char_op_kind(input logic [7:0] c);
      logic [5:0] k;
      k = KIND_NONE;
      unique case (c)
         8'h28:   k = 6'd0;
         8'h29:   k = 6'd1;
         8'h5B:   k = 6'd2;
         8'h5D:   k = 6'd3;
         8'h2C:   k = 6'd4;
         8'h2E:   k = 6'd5;
         8'h3A:   k = 6'd6;
         8'h2B:   k = 6'd7;
         8'h2D:   k = 6'd8;
         8'h2F:   k = 6'd11;
         8'h5E:   k = 6'd22;
         8'h7E:   k = 6'd23;
         default: k = KIND_NONE;
      endcase
      return k;
   endfunction

   function automatic logic [5:0] single_kind(input logic [7:0] p);
      logic [5:0] k;
      k = KIND_ERROR;
      unique case (p)
         8'h2A:   k = 6'd9;
         8'h3E:   k = 6'd12;
         8'h3C:   k = 6'd15;
         8'h26:   k = 6'd19;
         8'h7C:   k = 6'd21;
         8'h21:   k = 6'd24;
         8'h3D:   k = 6'd26;
         default: k = KIND_ERROR;
      endcase
      return k;
   endfunction

   function automatic logic [5:0] pair_kind(input logic [7:0] p, input logic [7:0] c);
      logic [5:0] k;
      k = KIND_NONE;
      priority if (p == 8'h2A && c == 8'h2A) k = 6'd10;
      else if (p == 8'h3E && c == 8'h3E) k = 6'd14;
      else if (p == 8'h3E && c == 8'h3D) k = 6'd13;
      else if (p == 8'h3C && c == 8'h3C) k = 6'd17;
      else if (p == 8'h3C && c == 8'h3D) k = 6'd16;
      else if (p == 8'h26 && c == 8'h26) k = 6'd18;
      else if (p == 8'h7C && c == 8'h7C) k = 6'd20;
      else if (p == 8'h21 && c == 8'h3D) k = 6'd25;
      else if (p == 8'h3D && c == 8'h3D) k = 6'd27;
      else k = KIND_NONE;
      return k;
   endfunction

   // put the keyword's first letter in the lowest byte
   function automatic logic [63:0] kw_pack(input logic [63:0] s, input int n);
      logic [63:0] p;
      p = '0;
      for (int i = 0; i < 8; i++) begin
         if (i < n) p[8*i +: 8] = s[8*(n-1-i) +: 8];
      end
      return p;
   endfunction

   function automatic logic [5:0] word_kind(input logic [63:0] prefix,
                                            input logic [15:0] tlen);
      logic [5:0] k;
      k = KIND_IDENT;
      if (tlen <= 16'd8) begin
         for (int i = 0; i < 11; i++) begin
            if (tlen == 16'(KW_LEN[i]) && prefix == kw_pack(KW_STR[i], int'(KW_LEN[i])))
               k = KIND_KW0 + 6'(i);
         end
      end
      return k;
   endfunction

endpackage

FILE: hdl/iat_div.sv
// Restoring divider, one quotient bit per cycle: leading spaces over indent width.
// Depends on iat_pkg.
module iat_div
   import iat_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic [SPACE_W-1:0] dividend,
   input  logic [3:0]         divisor,
   output logic               busy,
   output logic [SPACE_W-1:0] quot,
   output logic [3:0]         rem
);

   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic [SPACE_W-1:0]   q_ff, q_in;
   logic [3:0]           r_ff, r_in;
   logic [4:0]           r_sh;

   always_comb begin
      cnt_in = cnt_ff;
      q_in   = q_ff;
      r_in   = r_ff;
      r_sh   = {r_ff, q_ff[SPACE_W-1]};
      if (start) begin
         cnt_in = DIV_CNT_W'(DIV_STEPS);
         q_in   = dividend;
         r_in   = '0;
      end else if (cnt_ff != '0) begin
         cnt_in = cnt_ff - 1'b1;
         if (r_sh >= {1'b0, divisor}) begin
            r_in = 4'(r_sh - {1'b0, divisor});
            q_in = {q_ff[SPACE_W-2:0], 1'b1};
         end else begin
            r_in = r_sh[3:0];
            q_in = {q_ff[SPACE_W-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
      q_ff <= q_in;
      r_ff <= r_in;
   end

   assign busy = (cnt_ff != '0);
   assign quot = q_ff;
   assign rem  = r_ff;

endmodule

FILE: hdl/iat_dp.sv
// Tokenizer datapath: scan state, positions, indent stack, result staging and output register.
// Depends on iat_pkg and iat_div.
module iat_dp
   import iat_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  cmd_type     cmd,
   input  logic [7:0]  in_byte,
   input  logic [3:0]  indent_width,
   output status_type  status,
   output tok_type     rsp_tok,
   output logic        rsp_valid,
   output logic        rsp_last,
   input  logic        rsp_ready
);

   typedef enum logic [3:0] {
      M_IDLE, M_OP2, M_INT, M_FRAC, M_WORD, M_STR, M_ESC, M_CHR1, M_CHR2
   } mode_type;

   logic [7:0]               c_ff, c_in;
   logic [POSITION_BITS-1:0] pos_ff, pos_in, pos_inc, begin_ff, begin_in;
   logic [23:0]              line_ff, line_in, line_inc;
   logic [15:0]              col_ff, col_in, col_inc;
   logic                     ls_ff, ls_in;
   logic [SPACE_W-1:0]       space_ff, space_in;
   logic [15:0]              tlen_ff, tlen_in, tlen_inc;
   logic [7:0]               stack_ff [MAX_INDENT_DEPTH];
   logic [TOP_W-1:0]         top_ff, top_in;
   logic                     push_en;
   logic [7:0]               level_ff, level_in, level_div, top_val;
   logic [POPS_W-1:0]        pops_ff, pops_in;
   mode_type                 mode_ff, mode_in;
   logic [7:0]               pend_ff, pend_in;
   logic [63:0]              prefix_ff, prefix_in;

   tok_type                  stage_ff, stage_in, out_ff, out_in, em;
   logic                     stage_vld_ff, stage_vld_in, out_vld_ff, out_vld_in;
   logic                     last_ff, last_in, emit_en;

   logic                     div_busy;
   logic [SPACE_W-1:0]       quot;
   logic [3:0]               rem, div_w;
   logic [5:0]               pk, op1;
   logic                     out_free;

   assign div_w = (indent_width == 4'd0) ? 4'd1 : indent_width;

   iat_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd == CMD_DIV_START),
      .dividend (space_ff),
      .divisor  (div_w),
      .busy     (div_busy),
      .quot     (quot),
      .rem      (rem)
   );

   assign pos_inc   = (pos_ff == '1) ? pos_ff : pos_ff + 1'b1;
   assign col_inc   = (col_ff == '1) ? col_ff : col_ff + 1'b1;
   assign line_inc  = (line_ff == '1) ? line_ff : line_ff + 1'b1;
   assign tlen_inc  = (tlen_ff == '1) ? tlen_ff : tlen_ff + 1'b1;
   assign level_div = (quot[SPACE_W-1:8] != '0) ? 8'hFF : quot[7:0];
   assign top_val   = stack_ff[top_ff];
   assign pk        = pair_kind(pend_ff, c_ff);
   assign op1       = char_op_kind(c_ff);
   assign out_free  = !out_vld_ff || rsp_ready;

   // status for the controller
   always_comb begin
      status = '0;
      status.can_push   = !stage_vld_ff || out_free;
      status.line_start = ls_ff;
      status.char_space = (c_ff == CH_SPACE);
      status.div_busy   = div_busy;
      status.char_emit  = !((c_ff == CH_SPACE) || is_op2_start(c_ff) || (c_ff == CH_DQ) ||
                            (c_ff == CH_SQ) || is_digit(c_ff) || is_alpha(c_ff) ||
                            (c_ff == CH_USCORE));
      unique case (mode_ff)
         M_OP2: begin
            status.pre_emit = 1'b1;
            status.pre_scan = (pk == KIND_NONE);
         end
         M_INT: begin
            status.pre_emit = !is_digit(c_ff) && (c_ff != CH_DOT);
            status.pre_scan = status.pre_emit;
         end
         M_FRAC: begin
            status.pre_emit = !is_digit(c_ff);
            status.pre_scan = status.pre_emit;
         end
         M_WORD: begin
            status.pre_emit = !is_word(c_ff);
            status.pre_scan = status.pre_emit;
         end
         M_STR, M_ESC: begin
            status.pre_emit = (c_ff == CH_NUL) || (mode_ff == M_STR && c_ff == CH_DQ);
            status.pre_scan = (c_ff == CH_NUL);
         end
         M_CHR1: begin
            status.pre_emit = (c_ff == CH_NUL);
            status.pre_scan = (c_ff == CH_NUL);
         end
         M_CHR2: begin
            status.pre_emit = 1'b1;
            status.pre_scan = (c_ff != CH_SQ);
         end
         default: begin
            status.pre_scan = 1'b1;
         end
      endcase
      status.settle_emit = (rem != 4'd0) || (level_div > top_val);
      status.settle_pop  = (rem == 4'd0) && (level_div < top_val);
      status.pop_more    = (top_ff != '0) && (level_ff < top_val);
      status.pop_emit    = status.pop_more && (pops_ff < POPS_W'(DEDENT_CAP));
   end

   always_comb begin
      c_in      = c_ff;
      pos_in    = pos_ff;
      begin_in  = begin_ff;
      line_in   = line_ff;
      col_in    = col_ff;
      ls_in     = ls_ff;
      space_in  = space_ff;
      tlen_in   = tlen_ff;
      top_in    = top_ff;
      push_en   = 1'b0;
      level_in  = level_ff;
      pops_in   = pops_ff;
      mode_in   = mode_ff;
      pend_in   = pend_ff;
      prefix_in = prefix_ff;
      emit_en   = 1'b0;
      em.kind   = KIND_ERROR;
      em.err    = ERR_NONE;
      em.start  = 24'(begin_ff);
      em.len    = tlen_ff;
      em.line   = line_ff;
      em.col    = col_ff;

      unique case (cmd)
         CMD_LOAD: c_in = in_byte;

         CMD_PRE: begin
            unique case (mode_ff)
               M_OP2: begin
                  mode_in = M_IDLE;
                  emit_en = 1'b1;
                  if (pk != KIND_NONE) begin
                     pos_in  = pos_inc;
                     col_in  = col_inc;
                     em.kind = pk;
                     em.len  = 16'd2;
                     em.col  = col_inc;
                  end else begin
                     em.kind = single_kind(pend_ff);
                     em.err  = (em.kind == KIND_ERROR) ? ERR_BAD_BYTE : ERR_NONE;
                     em.len  = 16'd1;
                  end
               end
               M_INT, M_FRAC: begin
                  if (is_digit(c_ff) || (mode_ff == M_INT && c_ff == CH_DOT)) begin
                     tlen_in = tlen_inc;
                     pos_in  = pos_inc;
                     col_in  = col_inc;
                     if (c_ff == CH_DOT) mode_in = M_FRAC;
                  end else begin
                     mode_in = M_IDLE;
                     emit_en = 1'b1;
                     em.kind = (mode_ff == M_INT) ? KIND_INT : KIND_FLOAT;
                  end
               end
               M_WORD: begin
                  if (is_word(c_ff)) begin
                     for (int i = 0; i < 8; i++) begin
                        if (tlen_ff < 16'd8 && tlen_ff[2:0] == 3'(i))
                           prefix_in[8*i +: 8] = c_ff;
                     end
                     tlen_in = tlen_inc;
                     pos_in  = pos_inc;
                     col_in  = col_inc;
                  end else begin
                     mode_in = M_IDLE;
                     emit_en = 1'b1;
                     em.kind = word_kind(prefix_ff, tlen_ff);
                  end
               end
               M_STR, M_ESC: begin
                  priority if (c_ff == CH_NUL) begin
                     mode_in = M_IDLE;
                     emit_en = 1'b1;
                     em.err  = ERR_OPEN_STR;
                  end else if (mode_ff == M_ESC) begin
                     tlen_in = tlen_inc;
                     pos_in  = pos_inc;
                     col_in  = col_inc;
                     mode_in = M_STR;
                  end else if (c_ff == CH_BS) begin
                     tlen_in = tlen_inc;
                     pos_in  = pos_inc;
                     col_in  = col_inc;
                     mode_in = M_ESC;
                  end else if (c_ff == CH_DQ) begin
                     pos_in  = pos_inc;
                     col_in  = col_inc;
                     mode_in = M_IDLE;
                     emit_en = 1'b1;
                     em.kind = KIND_STRING;
                     em.col  = col_inc;
                  end else begin
                     tlen_in = tlen_inc;
                     pos_in  = pos_inc;
                     col_in  = col_inc;
                  end
               end
               M_CHR1: begin
                  if (c_ff == CH_NUL) begin
                     mode_in = M_IDLE;
                     emit_en = 1'b1;
                     em.err  = ERR_CHAR_LIT;
                     em.len  = 16'd0;
                  end else begin
                     pos_in  = pos_inc;
                     col_in  = col_inc;
                     mode_in = M_CHR2;
                  end
               end
               M_CHR2: begin
                  mode_in = M_IDLE;
                  emit_en = 1'b1;
                  em.len  = 16'd1;
                  if (c_ff == CH_SQ) begin
                     pos_in  = pos_inc;
                     col_in  = col_inc;
                     em.kind = KIND_CHAR;
                     em.col  = col_inc;
                  end else begin
                     em.err  = ERR_CHAR_LIT;
                  end
               end
               default: mode_in = M_IDLE;
            endcase
         end

         CMD_LS_SPACE: begin
            space_in = (space_ff == '1) ? space_ff : space_ff + 1'b1;
            pos_in   = pos_inc;
            col_in   = col_inc;
         end

         CMD_SETTLE: begin
            em.len = space_ff;
            priority if (rem != 4'd0) begin
               emit_en = 1'b1;
               em.err  = ERR_INDENT;
            end else if (level_div > top_val) begin
               emit_en = 1'b1;
               if (top_ff == TOP_W'(MAX_INDENT_DEPTH - 1)) begin
                  em.err = ERR_INDENT_OVF;
               end else begin
                  top_in  = top_ff + 1'b1;
                  push_en = 1'b1;
                  em.kind = KIND_INDENT;
               end
            end else begin
               em.kind = KIND_INDENT;
            end
            level_in = level_div;
            pops_in  = '0;
            if (!((rem == 4'd0) && (level_div < top_val))) begin
               ls_in    = 1'b0;
               space_in = '0;
            end
         end

         CMD_POP: begin
            top_in  = top_ff - 1'b1;
            emit_en = (pops_ff < POPS_W'(DEDENT_CAP));
            if (emit_en) pops_in = pops_ff + 1'b1;
            em.kind = KIND_DEDENT;
            em.len  = space_ff;
         end

         CMD_SETTLE_END: begin
            ls_in    = 1'b0;
            space_in = '0;
         end

         CMD_CHAR: begin
            begin_in = pos_ff;
            em.start = 24'(pos_ff);
            em.len   = 16'd1;
            em.col   = col_inc;
            priority if (c_ff == CH_SPACE) begin
               pos_in = pos_inc;
               col_in = col_inc;
            end else if (op1 != KIND_NONE) begin
               pos_in  = pos_inc;
               col_in  = col_inc;
               emit_en = 1'b1;
               em.kind = op1;
            end else if (is_op2_start(c_ff)) begin
               pend_in = c_ff;
               mode_in = M_OP2;
               pos_in  = pos_inc;
               col_in  = col_inc;
            end else if (c_ff == CH_NUL) begin
               col_in  = col_inc;
               emit_en = 1'b1;
               em.kind = KIND_EOF;
               em.len  = 16'd0;
            end else if (c_ff == CH_NL) begin
               pos_in   = pos_inc;
               begin_in = pos_inc;
               line_in  = line_inc;
               col_in   = '0;
               ls_in    = 1'b1;
               emit_en  = 1'b1;
               em.kind  = KIND_EOL;
               em.line  = line_inc;
               em.col   = '0;
            end else if (c_ff == CH_DQ || c_ff == CH_SQ) begin
               pos_in   = pos_inc;
               col_in   = col_inc;
               begin_in = pos_inc;
               tlen_in  = '0;
               mode_in  = (c_ff == CH_DQ) ? M_STR : M_CHR1;
            end else if (is_digit(c_ff)) begin
               tlen_in = 16'd1;
               mode_in = M_INT;
               pos_in  = pos_inc;
               col_in  = col_inc;
            end else if (is_alpha(c_ff) || c_ff == CH_USCORE) begin
               tlen_in   = 16'd1;
               prefix_in = {56'd0, c_ff};
               mode_in   = M_WORD;
               pos_in    = pos_inc;
               col_in    = col_inc;
            end else begin
               pos_in  = pos_inc;
               col_in  = col_inc;
               emit_en = 1'b1;
               em.err  = ERR_BAD_BYTE;
            end
         end

         default: ;
      endcase
   end

   // staging: a result waits in the stage until the next one shows whether it ends the run
   always_comb begin
      stage_in     = stage_ff;
      stage_vld_in = stage_vld_ff;
      out_in       = out_ff;
      last_in      = last_ff;
      out_vld_in   = out_vld_ff && !rsp_ready;
      if (emit_en) begin
         if (stage_vld_ff) begin
            out_in     = stage_ff;
            last_in    = 1'b0;
            out_vld_in = 1'b1;
         end
         stage_in     = em;
         stage_vld_in = 1'b1;
      end else if (cmd == CMD_FLUSH && stage_vld_ff) begin
         out_in       = stage_ff;
         last_in      = 1'b1;
         out_vld_in   = 1'b1;
         stage_vld_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff       <= '0;
         begin_ff     <= '0;
         line_ff      <= 24'd1;
         col_ff       <= '0;
         ls_ff        <= 1'b1;
         space_ff     <= '0;
         tlen_ff      <= '0;
         top_ff       <= '0;
         mode_ff      <= M_IDLE;
         pend_ff      <= '0;
         prefix_ff    <= '0;
         stage_vld_ff <= 1'b0;
         out_vld_ff   <= 1'b0;
         stack_ff[0]  <= '0;
      end else begin
         pos_ff       <= pos_in;
         begin_ff     <= begin_in;
         line_ff      <= line_in;
         col_ff       <= col_in;
         ls_ff        <= ls_in;
         space_ff     <= space_in;
         tlen_ff      <= tlen_in;
         top_ff       <= top_in;
         mode_ff      <= mode_in;
         pend_ff      <= pend_in;
         prefix_ff    <= prefix_in;
         stage_vld_ff <= stage_vld_in;
         out_vld_ff   <= out_vld_in;
         if (push_en) stack_ff[top_in] <= level_div;
      end
      c_ff     <= c_in;
      level_ff <= level_in;
      pops_ff  <= pops_in;
      stage_ff <= stage_in;
      out_ff   <= out_in;
      last_ff  <= last_in;
   end

   assign rsp_tok   = out_ff;
   assign rsp_valid = out_vld_ff;
   assign rsp_last  = last_ff;

endmodule

FILE: hdl/iat_ctrl.sv
// Tokenizer controller: sequences one source byte through close, indent and scan phases.
// Depends on iat_pkg; drives iat_dp through command and status.
module iat_ctrl
   import iat_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  status_type status,
   output cmd_type    cmd
);

   typedef enum logic [2:0] {
      S_WAIT, S_PRE, S_SCAN, S_DIV, S_SETTLE, S_POP, S_CHAR, S_FIN
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in  = state_ff;
      cmd       = CMD_NONE;
      req_ready = 1'b0;
      unique case (state_ff)
         S_WAIT: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd      = CMD_LOAD;
               state_in = S_PRE;
            end
         end
         S_PRE: begin
            if (!status.pre_emit || status.can_push) begin
               cmd = CMD_PRE;
               priority if (!status.pre_scan) state_in = S_FIN;
               else if (status.line_start)    state_in = S_SCAN;
               else                           state_in = S_CHAR;
            end
         end
         S_SCAN: begin
            if (status.char_space) begin
               cmd      = CMD_LS_SPACE;
               state_in = S_FIN;
            end else begin
               cmd      = CMD_DIV_START;
               state_in = S_DIV;
            end
         end
         S_DIV: begin
            if (!status.div_busy) state_in = S_SETTLE;
         end
         S_SETTLE: begin
            if (!status.settle_emit || status.can_push) begin
               cmd      = CMD_SETTLE;
               state_in = status.settle_pop ? S_POP : S_CHAR;
            end
         end
         S_POP: begin
            if (!status.pop_more) begin
               cmd      = CMD_SETTLE_END;
               state_in = S_CHAR;
            end else if (!status.pop_emit || status.can_push) begin
               cmd = CMD_POP;
            end
         end
         S_CHAR: begin
            if (!status.char_emit || status.can_push) begin
               cmd      = CMD_CHAR;
               state_in = S_FIN;
            end
         end
         S_FIN: begin
            if (status.can_push) begin
               cmd      = CMD_FLUSH;
               state_in = S_WAIT;
            end
         end
         default: state_in = S_WAIT;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_WAIT;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

FILE: hdl/indent_aware_tokenizer.sv
// Top level of the indentation-aware tokenizer: configuration register and block wiring.
// Depends on iat_pkg, iat_ctrl, iat_dp (and iat_div below it).
//
//  channel | direction | transfer when             | payload
//  req     | in        | req_tvalid & req_tready   | one source byte, zero = end of input
//  rsp     | out       | rsp_tvalid & rsp_tready   | one token; tlast on the byte's last token
//  csr     | in/out    | psel&penable&pwrite       | indent_width at byte address 0
//
// A byte scanned in idle mode goes through accept, close open token, scan and flush of the
// staged token; a byte that only extends or closes an open token skips the scan. The first
// non-space byte of a line adds a divide start, the serial divide of the space count by
// indent_width and a settle step, and a dedent adds a pop step per level popped plus one
// step to end the burst. A token waits in a staging register until the next one
// shows whether it ends the run, then moves to the output register; the next byte is
// taken while the last token still waits there. A stalled rsp side holds the sequencer
// only when a token must move into a full output register. Reset is synchronous and
// clears the scanner to line one, column zero, indent stack empty and indent_width 4.
module indent_aware_tokenizer
   import iat_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   // req_tdata: [7:0] char_byte
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,
   // rsp_tdata: [5:0] token_kind, [8:6] error_code, [32:9] token_start,
   //   [48:33] token_length, [72:49] line_number, [88:73] column_number, [95:89] zero
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [95:0] rsp_tdata,
   output logic        rsp_tlast,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   logic [3:0] width_ff;
   status_type status;
   cmd_type    cmd;
   tok_type    tok;

   // register write on the access cycle
   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff <= 4'd4;
      end else if (csr_psel && csr_penable && csr_pwrite && csr_pready &&
                   csr_paddr[2] == REG_INDENT_WIDTH) begin
         width_ff <= csr_pwdata[3:0];
      end
   end

   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr[2] == REG_INDENT_WIDTH) ? {28'd0, width_ff} : 32'd0;

   iat_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_tvalid),
      .req_ready (req_tready),
      .status    (status),
      .cmd       (cmd)
   );

   iat_dp u_dp (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .in_byte      (req_tdata),
      .indent_width (width_ff),
      .status       (status),
      .rsp_tok      (tok),
      .rsp_valid    (rsp_tvalid),
      .rsp_last     (rsp_tlast),
      .rsp_ready    (rsp_tready)
   );

   // pack fields from the lowest bit up
   assign rsp_tdata = {7'd0, tok.col, tok.line, tok.len, tok.start, tok.err, tok.kind};

endmodule

FILE: bench/tb_indent_aware_tokenizer.sv
// Self-checking bench for indent_aware_tokenizer: byte stream in, token stream out.
// Uses iat_pkg for token kinds and error codes; needs only the RTL to run.
`timescale 1ns / 100ps

module tb_indent_aware_tokenizer;
   import iat_pkg::*;

   localparam int CYCLE_LIMIT = 600000;
   localparam int SETTLE_CYCLES = 64;   // divide plus full pop burst plus pipeline

   // operator kinds, dense from zero
   typedef enum logic [5:0] {
      OP_LPAREN, OP_RPAREN, OP_LBRACK, OP_RBRACK, OP_COMMA, OP_DOT, OP_COLON,
      OP_PLUS, OP_MINUS, OP_STAR, OP_POW, OP_SLASH, OP_GT, OP_GE, OP_SHR,
      OP_LT, OP_LE, OP_SHL, OP_LAND, OP_AND, OP_LOR, OP_OR, OP_XOR, OP_TILDE,
      OP_NOT, OP_NE, OP_ASSIGN, OP_EQ
   } op_kind_type;

   typedef enum logic [3:0] {
      SC_IDLE, SC_OP2, SC_INT, SC_FRAC, SC_WORD, SC_STR, SC_ESC, SC_CHR1, SC_CHR2
   } scan_type;

   typedef struct packed {
      logic [5:0]  kind;
      logic [2:0]  err;
      logic [23:0] start;
      logic [15:0] len;
      logic [23:0] line;
      logic [15:0] col;
      logic        last;
   } token_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = '0;    // [7:0] char_byte
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [95:0] rsp_tdata;         // [5:0] kind, [8:6] err, [32:9] start, [48:33] length,
                                   // [72:49] line, [88:73] column, [95:89] zero
   logic        rsp_tlast;
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [2:0]  csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   indent_aware_tokenizer DUT (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // ------------------------------------------------------------------
   // Token predictor: a byte-at-a-time copy of the scanner state
   // ------------------------------------------------------------------
   logic [3:0]  indent_width_q;
   int unsigned pos_q, tok_begin, line_q, col_q, spaces_q, text_len;
   bit          line_start;
   logic [7:0]  levels [16];
   int unsigned top_q;
   scan_type    mode_q;
   logic [7:0]  held_op;
   logic [63:0] word_head;
   string       keywords [11] = '{"break", "continue", "else", "false", "function", "if",
                                  "let", "nil", "return", "true", "while"};

   token_type step_tokens [$];
   token_type expected_tokens [$];
   logic [7:0] byte_queue [$];
   int bytes_sent, tokens_seen, errors;

   function automatic bit is_dig(logic [7:0] c);
      return c >= "0" && c <= "9";
   endfunction

   function automatic bit is_let(logic [7:0] c);
      return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
   endfunction

   function void tokenizer_reset();
      indent_width_q = 4'd4;
      pos_q = 0; tok_begin = 0; line_q = 1; col_q = 0; spaces_q = 0; text_len = 0;
      line_start = 1'b1;
      foreach (levels[i]) levels[i] = '0;
      top_q = 0; mode_q = SC_IDLE; held_op = '0; word_head = '0;
   endfunction

   function void emit(logic [5:0] kind, logic [2:0] err, int unsigned start,
                      int unsigned len);
      token_type t;
      if (step_tokens.size() >= 19) return;
      t.kind = kind; t.err = err; t.start = start[23:0];
      t.len = len > 65535 ? 16'hFFFF : len[15:0];
      t.line = line_q[23:0]; t.col = col_q[15:0]; t.last = 1'b0;
      step_tokens.push_back(t);
   endfunction

   function void advance();
      if (pos_q < 24'hFFFFFF) pos_q++;
      if (col_q < 65535) col_q++;
   endfunction

   function void grow();
      if (text_len < 65535) text_len++;
   endfunction

   function void add_letter(logic [7:0] c);
      if (text_len < 8) word_head[8*text_len +: 8] = c;
      grow();
   endfunction

   function logic [5:0] word_class();
      logic [63:0] packed_kw;
      if (text_len > 8) return KIND_IDENT;
      for (int k = 0; k < 11; k++) begin
         packed_kw = '0;
         for (int i = 0; i < keywords[k].len(); i++) packed_kw[8*i +: 8] = keywords[k][i];
         if (keywords[k].len() == text_len && packed_kw == word_head)
            return KIND_KW0 + 6'(k);
      end
      return KIND_IDENT;
   endfunction

   function automatic logic [5:0] plain_op(logic [7:0] c);
      case (c)
         "(": return OP_LPAREN;  ")": return OP_RPAREN;
         "[": return OP_LBRACK;  "]": return OP_RBRACK;
         ",": return OP_COMMA;   ".": return OP_DOT;
         ":": return OP_COLON;   "+": return OP_PLUS;
         "-": return OP_MINUS;   "/": return OP_SLASH;
         "^": return OP_XOR;     "~": return OP_TILDE;
         default: return KIND_NONE;
      endcase
   endfunction

   function automatic logic [5:0] lone_op(logic [7:0] p);
      case (p)
         "*": return OP_STAR;  ">": return OP_GT;  "<": return OP_LT;
         "&": return OP_AND;   "|": return OP_OR;  "!": return OP_NOT;
         "=": return OP_ASSIGN;
         default: return KIND_ERROR;
      endcase
   endfunction

   function automatic logic [5:0] paired_op(logic [7:0] p, logic [7:0] c);
      if (p == "*" && c == "*") return OP_POW;
      if (p == ">" && c == ">") return OP_SHR;
      if (p == ">" && c == "=") return OP_GE;
      if (p == "<" && c == "<") return OP_SHL;
      if (p == "<" && c == "=") return OP_LE;
      if (p == "&" && c == "&") return OP_LAND;
      if (p == "|" && c == "|") return OP_LOR;
      if (p == "!" && c == "=") return OP_NE;
      if (p == "=" && c == "=") return OP_EQ;
      return KIND_NONE;
   endfunction

   // turn the leading space count into indent, dedents or an error
   function void settle_level();
      int unsigned w, lvl, pops;
      w = indent_width_q == 0 ? 1 : indent_width_q;
      pops = 0;
      if (spaces_q % w != 0) begin
         emit(KIND_ERROR, ERR_INDENT, tok_begin, spaces_q);
         return;
      end
      lvl = spaces_q / w;
      if (lvl > 255) lvl = 255;
      if (top_q >= 16) top_q = 15;
      if (lvl > levels[top_q]) begin
         if (top_q + 1 >= 16) emit(KIND_ERROR, ERR_INDENT_OVF, tok_begin, spaces_q);
         else begin
            top_q++;
            levels[top_q] = lvl[7:0];
            emit(KIND_INDENT, ERR_NONE, tok_begin, spaces_q);
         end
      end else begin
         while (top_q > 0 && lvl < levels[top_q]) begin
            top_q--;
            if (pops < 17) emit(KIND_DEDENT, ERR_NONE, tok_begin, spaces_q);
            pops++;
         end
      end
   endfunction

   function void scan_fresh(logic [7:0] c);
      logic [5:0] k;
      if (line_start) begin
         if (c == CH_SPACE) begin
            if (spaces_q < 65535) spaces_q++;
            advance();
            return;
         end
         settle_level();
         line_start = 1'b0;
         spaces_q = 0;
      end
      tok_begin = pos_q;
      k = plain_op(c);
      if (c == CH_SPACE) advance();
      else if (k != KIND_NONE) begin
         advance();
         emit(k, ERR_NONE, tok_begin, 1);
      end else if (lone_op(c) != KIND_ERROR) begin
         held_op = c; mode_q = SC_OP2; advance();
      end else if (c == CH_NUL) begin
         if (col_q < 65535) col_q++;
         emit(KIND_EOF, ERR_NONE, pos_q, 0);
      end else if (c == CH_NL) begin
         advance();
         if (line_q < 24'hFFFFFF) line_q++;
         col_q = 0;
         line_start = 1'b1;
         emit(KIND_EOL, ERR_NONE, tok_begin, 1);
         tok_begin = pos_q;
      end else if (c == CH_DQ) begin
         advance(); tok_begin = pos_q; text_len = 0; mode_q = SC_STR;
      end else if (c == CH_SQ) begin
         advance(); tok_begin = pos_q; mode_q = SC_CHR1;
      end else if (is_dig(c)) begin
         text_len = 1; mode_q = SC_INT; advance();
      end else if (is_let(c)) begin
         text_len = 0; word_head = '0; add_letter(c); mode_q = SC_WORD; advance();
      end else begin
         advance();
         emit(KIND_ERROR, ERR_BAD_BYTE, tok_begin, 1);
      end
   endfunction

   // predict every token caused by one accepted byte
   function void predict_tokens(logic [7:0] c);
      logic [5:0] k;
      step_tokens.delete();
      case (mode_q)
         SC_OP2: begin
            mode_q = SC_IDLE;
            k = paired_op(held_op, c);
            if (k != KIND_NONE) begin
               advance();
               emit(k, ERR_NONE, tok_begin, 2);
            end else begin
               k = lone_op(held_op);
               emit(k, k == KIND_ERROR ? ERR_BAD_BYTE : ERR_NONE, tok_begin, 1);
               scan_fresh(c);
            end
         end
         SC_INT:
            if (is_dig(c)) begin grow(); advance(); end
            else if (c == CH_DOT) begin grow(); advance(); mode_q = SC_FRAC; end
            else begin
               mode_q = SC_IDLE; emit(KIND_INT, ERR_NONE, tok_begin, text_len); scan_fresh(c);
            end
         SC_FRAC:
            if (is_dig(c)) begin grow(); advance(); end
            else begin
               mode_q = SC_IDLE; emit(KIND_FLOAT, ERR_NONE, tok_begin, text_len);
               scan_fresh(c);
            end
         SC_WORD:
            if (is_let(c) || is_dig(c)) begin add_letter(c); advance(); end
            else begin
               mode_q = SC_IDLE; emit(word_class(), ERR_NONE, tok_begin, text_len);
               scan_fresh(c);
            end
         SC_STR, SC_ESC:
            if (c == CH_NUL) begin
               mode_q = SC_IDLE;
               emit(KIND_ERROR, ERR_OPEN_STR, tok_begin, text_len);
               scan_fresh(c);
            end else if (mode_q == SC_ESC) begin grow(); advance(); mode_q = SC_STR; end
            else if (c == CH_BS) begin grow(); advance(); mode_q = SC_ESC; end
            else if (c == CH_DQ) begin
               advance(); mode_q = SC_IDLE;
               emit(KIND_STRING, ERR_NONE, tok_begin, text_len);
            end else begin grow(); advance(); end
         SC_CHR1:
            if (c == CH_NUL) begin
               mode_q = SC_IDLE;
               emit(KIND_ERROR, ERR_CHAR_LIT, tok_begin, 0);
               scan_fresh(c);
            end else begin advance(); mode_q = SC_CHR2; end
         SC_CHR2: begin
            mode_q = SC_IDLE;
            if (c == CH_SQ) begin
               advance();
               emit(KIND_CHAR, ERR_NONE, tok_begin, 1);
            end else begin
               emit(KIND_ERROR, ERR_CHAR_LIT, tok_begin, 1);
               scan_fresh(c);
            end
         end
         default: begin
            mode_q = SC_IDLE;
            scan_fresh(c);
         end
      endcase
      if (step_tokens.size() > 0) step_tokens[step_tokens.size() - 1].last = 1'b1;
      foreach (step_tokens[i]) expected_tokens.push_back(step_tokens[i]);
   endfunction

   // ------------------------------------------------------------------
   // Byte driver: bursts of random length, random gaps between them
   // ------------------------------------------------------------------
   int burst_left, gap_left;

   always @(posedge clock) begin
      logic       next_valid;
      logic [7:0] next_data;
      next_valid = req_tvalid;
      next_data  = req_tdata;
      if (!reset) begin
         // a transfer happens on this edge: predict from the presented byte
         if (req_tvalid && req_tready) begin
            predict_tokens(req_tdata);
            bytes_sent++;
         end
         if (!req_tvalid || req_tready) begin
            next_valid = 1'b0;
            if (gap_left > 0) gap_left--;
            else if (byte_queue.size() > 0) begin
               next_valid = 1'b1;
               next_data  = byte_queue.pop_front();
               if (burst_left > 0) burst_left--;
               else begin
                  // pick the next burst; a quarter of the time run with no gaps
                  burst_left = $urandom_range(0, 12);
                  gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
               end
            end
         end
      end
      req_tvalid <= next_valid;
      req_tdata  <= next_data;
   end

   // ------------------------------------------------------------------
   // Token monitor and receiver stall pattern
   // ------------------------------------------------------------------
   int cycle_count;

   always @(posedge clock) begin
      token_type want, got;
      logic [1:0] stall_style;
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("%0t timeout with %0d tokens outstanding", $time, expected_tokens.size());
         $display("status: fail");
         $finish;
      end
      // change the stall style with upper bits of the cycle count: always ready, fixed 3-of-4, or random
      stall_style = cycle_count[8:7] ^ cycle_count[10:9];
      case (stall_style)
         2'd0, 2'd3: rsp_tready <= 1'b1;
         2'd1:       rsp_tready <= cycle_count[1:0] != 2'd0;
         default:    rsp_tready <= 1'($urandom_range(0, 1));
      endcase
      if (!reset && rsp_tvalid && rsp_tready) begin
         tokens_seen++;
         got = {rsp_tdata[5:0], rsp_tdata[8:6], rsp_tdata[32:9], rsp_tdata[48:33],
                rsp_tdata[72:49], rsp_tdata[88:73], rsp_tlast};
         if (expected_tokens.size() == 0) begin
            errors++;
            $display("%0t unexpected token: expected none, actual kind %0d err %0d st %0d",
                     $time, got.kind, got.err, got.start);
         end else begin
            want = expected_tokens.pop_front();
            if (got !== want) begin
               errors++;
               $display("%0t mismatch: expected kind %0d err %0d st %0d len %0d ln %0d col %0d l %0d",
                        $time, want.kind, want.err, want.start, want.len, want.line,
                        want.col, want.last);
               $display("%0t           actual   kind %0d err %0d st %0d len %0d ln %0d col %0d l %0d",
                        $time, got.kind, got.err, got.start, got.len, got.line,
                        got.col, got.last);
            end
         end
      end
   end

   // ------------------------------------------------------------------
   // Stimulus
   // ------------------------------------------------------------------
   task automatic put_text(string s);
      for (int i = 0; i < s.len(); i++) byte_queue.push_back(s[i]);
   endtask

   task automatic put_spaces(int n);
      repeat (n) byte_queue.push_back(CH_SPACE);
   endtask

   // hold until every byte is taken and every token has arrived, then let the block settle
   task automatic drain();
      while (byte_queue.size() > 0 || req_tvalid || expected_tokens.size() > 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic csr_write(logic [3:0] value);
      @(posedge clock);
      csr_psel <= 1'b1; csr_pwrite <= 1'b1; csr_penable <= 1'b0;
      csr_paddr <= {REG_INDENT_WIDTH, 2'b00}; csr_pwdata <= 32'(value);
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      indent_width_q = value;
      csr_psel <= 1'b0; csr_penable <= 1'b0; csr_pwrite <= 1'b0;
      // read back
      @(posedge clock);
      csr_psel <= 1'b1;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      if (csr_prdata[3:0] !== value) begin
         errors++;
         $display("%0t indent_width readback: expected %0d actual %0d", $time, value,
                  csr_prdata[3:0]);
      end
      csr_psel <= 1'b0; csr_penable <= 1'b0;
   endtask

   task automatic put_token();
      int pick;
      string ops = "()[],.:+-/^~*><&|!=";
      pick = $urandom_range(0, 11);
      case (pick)
         0: put_text(keywords[$urandom_range(0, 10)]);
         1, 2: begin
            int n;
            n = $urandom_range(1, 12);
            byte_queue.push_back($urandom_range(0, 1) ? CH_USCORE :
                                 8'("a" + $urandom_range(0, 25)));
            repeat (n - 1) begin
               case ($urandom_range(0, 2))
                  0: byte_queue.push_back(8'("a" + $urandom_range(0, 25)));
                  1: byte_queue.push_back(8'("A" + $urandom_range(0, 25)));
                  default: byte_queue.push_back(8'("0" + $urandom_range(0, 9)));
               endcase
            end
         end
         3: repeat ($urandom_range(1, 5)) byte_queue.push_back(8'("0" + $urandom_range(0, 9)));
         4: begin
            put_text($sformatf("%0d.", $urandom_range(0, 999)));
            if ($urandom_range(0, 2) != 0) put_text($sformatf("%0d", $urandom_range(0, 99)));
         end
         5: begin
            byte_queue.push_back(CH_DQ);
            repeat ($urandom_range(0, 6)) begin
               if ($urandom_range(0, 4) == 0) byte_queue.push_back(CH_BS);
               byte_queue.push_back(8'($urandom_range(1, 255)));
            end
            byte_queue.push_back(CH_DQ);
         end
         6: begin
            byte_queue.push_back(CH_SQ);
            byte_queue.push_back(8'($urandom_range(1, 255)));
            if ($urandom_range(0, 3) != 0) byte_queue.push_back(CH_SQ);
         end
         7, 8, 9: repeat ($urandom_range(1, 2))
            byte_queue.push_back(ops[$urandom_range(0, ops.len() - 1)]);
         10: byte_queue.push_back(CH_SPACE);
         default: byte_queue.push_back(8'($urandom_range(1, 255)));
      endcase
      if ($urandom_range(0, 1)) byte_queue.push_back(CH_SPACE);
   endtask

   // a program of lines with random content and some broken indentation
   task automatic put_program(int lines, int width);
      int depth;
      depth = 0;
      repeat (lines) begin
         case ($urandom_range(0, 5))
            0: depth = 0;
            1, 2: if (depth < 6) depth++;
            3: if (depth > 0) depth--;
            default: ;
         endcase
         put_spaces(depth * width + (($urandom_range(0, 9) == 0) ? 1 : 0));
         repeat ($urandom_range(0, 4)) put_token();
         if ($urandom_range(0, 19) == 0) begin
            // end of input, sometimes inside an open string
            if ($urandom_range(0, 1)) put_text("\"open");
            byte_queue.push_back(CH_NUL);
         end else byte_queue.push_back(CH_NL);
      end
   endtask

   initial begin
      logic [3:0] widths [5] = '{4'd1, 4'd8, 4'd3, 4'd2, 4'd4};
      tokenizer_reset();
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: every operator, literals, bad bytes, indent error, open literals at end
      put_text("if x**2>=y>>1<=z<<3&&a&b||c|d^~!e!=f==g=h*i>j<k\n");
      put_text("  ()[],.:+-/ 12 3.5 7. \"a\\\"b\" 'c' 'de");
      byte_queue.push_back(8'hFF); byte_queue.push_back(8'h80);
      byte_queue.push_back(8'h09); byte_queue.push_back(8'h0D);
      put_text("\n    x\n        y\n\n'");
      byte_queue.push_back(CH_NUL);
      put_text("\"s\\");
      byte_queue.push_back(CH_NUL);
      drain();

      // one random line at each of several indent widths, from 1 to 8
      foreach (widths[w]) begin
         csr_write(widths[w]);
         put_program(1, widths[w]);
         drain();
      end

      $display("covered %0d bytes and %0d tokens over indent widths 1 to 8,",
               bytes_sent, tokens_seen);
      $display("with stall patterns, indent errors, dedents and open literals at end");
      if (errors == 0 && expected_tokens.size() == 0) begin
         $display("status: pass");
      end else begin
         $display("%0d mismatches, %0d tokens never arrived", errors, expected_tokens.size());
         $display("status: fail");
      end
      $finish;
   end

endmodule
